[design/cpc_pkg.sv]
// shared constants, arctangent table and cell data type of the cartesian/polar converter
package cpc_pkg;

    localparam int ITERS     = 32;
    localparam int DP_W      = 64;
    localparam int Z_W       = 34;
    localparam int TURN_BITS = 32;
    localparam int UNIT_Q    = 30;

    // reciprocal of the cordic gain in q30
    localparam logic [DP_W-1:0] INV_GAIN_Q30 = 64'd652032874;

    // atan(2^-i) in units of 2^32 per turn
    localparam logic [31:0] ATAN_TURN32 [ITERS] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0
    };

    typedef struct packed {
        logic            vec;   // vectoring when set, rotation otherwise
        logic [DP_W-1:0] x;
        logic [DP_W-1:0] y;
        logic [Z_W-1:0]  z;
        logic [DP_W-1:0] s;     // square root remainder
        logic [DP_W-1:0] root;  // square root partial result
    } t_cell_data;

endpackage

[design/cpc_prep.sv]
// input capture, absolute values, squares and cordic seed values
module cpc_prep import cpc_pkg::*; #(
    parameter int COORD_WIDTH = 16,
    parameter int ANGLE_WIDTH = 16,
    parameter int SIDE_W      = 1 + 3 * 16 + 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  logic                   i_func,
    input  logic [COORD_WIDTH-1:0] i_x_in,
    input  logic [COORD_WIDTH-1:0] i_y_in,
    input  logic [COORD_WIDTH-1:0] i_radius_in,
    input  logic [ANGLE_WIDTH-1:0] i_angle_in,
    output logic                   o_valid,
    output t_cell_data             o_data,
    output logic [SIDE_W-1:0]      o_side
);

    localparam int CW        = COORD_WIDTH;
    localparam int AW        = ANGLE_WIDTH;
    localparam int PRE_SHIFT = 61 - CW;

    logic              r_a_valid;
    logic [SIDE_W-1:0] r_a_side;
    logic [CW-1:0]     r_a_ax;
    logic [CW-1:0]     r_a_ay;
    logic              r_b_valid;
    t_cell_data        r_b_data;
    logic [SIDE_W-1:0] r_b_side;

    logic [CW-1:0]        n_ax;
    logic [CW-1:0]        n_ay;
    logic [2*CW-1:0]      sq_x;
    logic [2*CW-1:0]      sq_y;
    logic [TURN_BITS-1:0] a_turn;
    logic                 a_func;
    logic [AW-1:0]        a_angle;
    t_cell_data           n_data;

    always_comb begin
        n_ax = i_x_in[CW-1] ? (~i_x_in + 1'b1) : i_x_in;
        n_ay = i_y_in[CW-1] ? (~i_y_in + 1'b1) : i_y_in;
    end

    assign a_func  = r_a_side[SIDE_W-1];
    assign a_angle = r_a_side[AW-1:0];

    always_comb begin
        sq_x   = r_a_ax * r_a_ax;
        sq_y   = r_a_ay * r_a_ay;
        a_turn = TURN_BITS'(a_angle) << (TURN_BITS - AW);
        n_data.vec  = !a_func;
        n_data.x    = a_func ? INV_GAIN_Q30 : (DP_W'(r_a_ax) << PRE_SHIFT);
        n_data.y    = a_func ? '0 : (DP_W'(r_a_ay) << PRE_SHIFT);
        n_data.z    = a_func ? Z_W'(a_turn[TURN_BITS-3:0]) : '0;
        n_data.s    = DP_W'(sq_x) + DP_W'(sq_y);
        n_data.root = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_side <= {i_func, i_x_in, i_y_in, i_radius_in, i_angle_in};
            r_a_ax   <= n_ax;
            r_a_ay   <= n_ay;
            r_b_data <= n_data;
            r_b_side <= r_a_side;
        end
    end

    assign o_valid = r_b_valid;
    assign o_data  = r_b_data;
    assign o_side  = r_b_side;

endmodule

[design/cpc_cell.sv]
// one cordic micro-rotation plus one square root digit step, registered
module cpc_cell import cpc_pkg::*; #(
    parameter int STAGE  = 0,
    parameter int SIDE_W = 1 + 3 * 16 + 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  t_cell_data        i_data,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output t_cell_data        o_data,
    output logic [SIDE_W-1:0] o_side
);

    localparam logic [DP_W-1:0] SQ_BIT    = DP_W'(64'd1 << (62 - 2 * STAGE));
    localparam logic [Z_W-1:0]  ATAN_STEP = Z_W'(ATAN_TURN32[STAGE]);

    logic              r_valid;
    t_cell_data        r_data;
    logic [SIDE_W-1:0] r_side;

    logic signed [DP_W-1:0] x_sh;
    logic signed [DP_W-1:0] y_sh;
    logic                   y_pos;
    logic                   dir_pos;
    logic [DP_W-1:0]        sq_try;
    t_cell_data             n_data;

    always_comb begin
        x_sh    = $signed(i_data.x) >>> STAGE;
        y_sh    = $signed(i_data.y) >>> STAGE;
        y_pos   = !i_data.y[DP_W-1] && (i_data.y != '0);
        // vectoring drives y toward zero, rotation drives z toward zero
        dir_pos = i_data.vec ? !y_pos : !i_data.z[Z_W-1];
        n_data.vec = i_data.vec;
        if (dir_pos) begin
            n_data.x = i_data.x - y_sh;
            n_data.y = i_data.y + x_sh;
            n_data.z = i_data.z - ATAN_STEP;
        end else begin
            n_data.x = i_data.x + y_sh;
            n_data.y = i_data.y - x_sh;
            n_data.z = i_data.z + ATAN_STEP;
        end
        sq_try = i_data.root + SQ_BIT;
        if (i_data.s >= sq_try) begin
            n_data.s    = i_data.s - sq_try;
            n_data.root = (i_data.root >> 1) + SQ_BIT;
        end else begin
            n_data.s    = i_data.s;
            n_data.root = i_data.root >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_side  = r_side;

endmodule

[design/cpc_post.sv]
// quadrant fold, rounding, radius scaling and saturation after the cell chain
module cpc_post import cpc_pkg::*; #(
    parameter int COORD_WIDTH = 16,
    parameter int ANGLE_WIDTH = 16,
    parameter int SIDE_W      = 1 + 3 * 16 + 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  logic                                 i_valid,
    input  t_cell_data                           i_data,
    input  logic [SIDE_W-1:0]                    i_side,
    output logic                                 o_valid,
    output logic [3*COORD_WIDTH+ANGLE_WIDTH-1:0] o_result
);

    localparam int CW = COORD_WIDTH;
    localparam int AW = ANGLE_WIDTH;
    localparam int PW = CW + Z_W;
    localparam int SH = TURN_BITS - AW;

    localparam logic [AW-1:0]  A_HALF    = {1'b1, {(AW-1){1'b0}}};
    localparam logic [AW-1:0]  A_QUARTER = {2'b01, {(AW-2){1'b0}}};
    localparam logic [Z_W-1:0] Z_QUARTER = Z_W'(64'd1 << (TURN_BITS - 2));
    localparam logic [PW:0]    SAT_HI    = {{(PW-CW+2){1'b0}}, {(CW-1){1'b1}}};
    localparam logic [PW:0]    SAT_LO    = SAT_HI + 1'b1;
    localparam logic [PW:0]    RND_HALF  = (PW+1)'(64'd1 << (UNIT_Q - 1));
    localparam logic [CW-1:0]  C_HI      = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0]  C_LO      = {1'b1, {(CW-1){1'b0}}};

    function automatic logic [CW-1:0] round_sat(input logic [PW-1:0] p);
        logic [PW-1:0] mag;
        logic [PW:0]   rnd;
        logic [PW:0]   neg_rnd;
        logic [CW-1:0] res;
        mag     = p[PW-1] ? (~p + 1'b1) : p;
        rnd     = ({1'b0, mag} + RND_HALF) >> UNIT_Q;
        neg_rnd = ~rnd + 1'b1;
        if (!p[PW-1]) begin
            res = (rnd > SAT_HI) ? C_HI : rnd[CW-1:0];
        end else begin
            res = (rnd > SAT_LO) ? C_LO : neg_rnd[CW-1:0];
        end
        return res;
    endfunction

    logic          s_func;
    logic [CW-1:0] s_x;
    logic [CW-1:0] s_y;
    logic [CW-1:0] s_r;
    logic [AW-1:0] s_angle;

    assign s_func  = i_side[SIDE_W-1];
    assign s_x     = i_side[AW+3*CW-1:AW+2*CW];
    assign s_y     = i_side[AW+2*CW-1:AW+CW];
    assign s_r     = i_side[AW+CW-1:AW];
    assign s_angle = i_side[AW-1:0];

    logic                 r1_valid;
    logic                 r1_func;
    logic                 r1_rneg;
    logic signed [PW-1:0] r1_px;
    logic signed [PW-1:0] r1_py;
    logic [CW-1:0]        r1_ex;
    logic [CW-1:0]        r1_ey;
    logic [CW-1:0]        r1_radius;
    logic [AW-1:0]        r1_angle;
    logic                 r2_valid;
    logic [3*CW+AW-1:0]   r2_result;

    logic [CW-1:0]         ax_abs;
    logic [CW-1:0]         ay_abs;
    logic                  x_zero;
    logic                  y_zero;
    logic [DP_W-1:0]       q_rnd;
    logic [30:0]           phi;
    logic [32:0]           phi_t;
    logic [AW-1:0]         phi_r;
    logic [AW-1:0]         fold;
    logic [CW-1:0]         rect_radius;
    logic [AW-1:0]         rect_angle;
    logic signed [Z_W-1:0] cos_u;
    logic signed [Z_W-1:0] sin_u;
    logic signed [Z_W-1:0] c_map;
    logic signed [Z_W-1:0] s_map;
    logic signed [PW-1:0]  n1_px;
    logic signed [PW-1:0]  n1_py;
    logic                  rneg;
    logic [CW-1:0]         n2_x;
    logic [CW-1:0]         n2_y;

    // rectangular to polar: radius rounding, angle clamp, rounding and fold
    always_comb begin
        ax_abs = s_x[CW-1] ? (~s_x + 1'b1) : s_x;
        ay_abs = s_y[CW-1] ? (~s_y + 1'b1) : s_y;
        x_zero = (s_x == '0);
        y_zero = (s_y == '0);
        q_rnd  = i_data.root + DP_W'(i_data.s > i_data.root);
        if (i_data.z[Z_W-1]) begin
            phi = '0;
        end else if (i_data.z > Z_QUARTER) begin
            phi = Z_QUARTER[30:0];
        end else begin
            phi = i_data.z[30:0];
        end
        // adding a half lsb and shifting one extra bit also covers a zero shift
        phi_t = {1'b0, phi, 1'b0} + 33'(64'd1 << SH);
        phi_r = AW'(phi_t >> (SH + 1));
        if (!s_x[CW-1]) begin
            fold = s_y[CW-1] ? (~phi_r + 1'b1) : phi_r;
        end else begin
            fold = s_y[CW-1] ? (A_HALF + phi_r) : (A_HALF - phi_r);
        end
        priority if (x_zero && y_zero) begin
            rect_radius = '0;
            rect_angle  = '0;
        end else if (x_zero) begin
            rect_radius = ay_abs;
            rect_angle  = s_y[CW-1] ? (A_QUARTER + A_HALF) : A_QUARTER;
        end else if (y_zero) begin
            rect_radius = ax_abs;
            rect_angle  = s_x[CW-1] ? A_HALF : '0;
        end else begin
            rect_radius = q_rnd[CW-1:0];
            rect_angle  = fold;
        end
    end

    // polar to rectangular: quadrant map and scaling by the radius
    always_comb begin
        cos_u = $signed(i_data.x[Z_W-1:0]);
        sin_u = $signed(i_data.y[Z_W-1:0]);
        unique case (s_angle[AW-1:AW-2])
            2'd0: begin
                c_map = cos_u;
                s_map = sin_u;
            end
            2'd1: begin
                c_map = -sin_u;
                s_map = cos_u;
            end
            2'd2: begin
                c_map = -cos_u;
                s_map = -sin_u;
            end
            default: begin
                c_map = sin_u;
                s_map = -cos_u;
            end
        endcase
        n1_px = $signed(s_r) * c_map;
        n1_py = $signed(s_r) * s_map;
        rneg  = s_r[CW-1];
    end

    always_comb begin
        if (!r1_func) begin
            n2_x = r1_ex;
            n2_y = r1_ey;
        end else if (r1_rneg) begin
            n2_x = '0;
            n2_y = '0;
        end else begin
            n2_x = round_sat(r1_px);
            n2_y = round_sat(r1_py);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_func   <= s_func;
            r1_rneg   <= rneg;
            r1_px     <= n1_px;
            r1_py     <= n1_py;
            r1_ex     <= s_x;
            r1_ey     <= s_y;
            if (!s_func) begin
                r1_radius <= rect_radius;
                r1_angle  <= rect_angle;
            end else begin
                r1_radius <= rneg ? '0 : s_r;
                r1_angle  <= rneg ? '0 : s_angle;
            end
            r2_result <= {n2_x, n2_y, r1_radius, r1_angle};
        end
    end

    assign o_valid  = r2_valid;
    assign o_result = r2_result;

endmodule

[design/cartesian_polar_converter_core.sv]
// top level of the cartesian/polar converter: cell chain and output skid stage
//
// One conversion per beat. i_func = 0 takes i_x_in, i_y_in and returns the
// magnitude and angle (a fraction of a turn); i_func = 1 takes i_radius_in,
// i_angle_in and returns x and y. Every result beat carries all four fields.
// Input channel: i_valid with o_stall; a beat is taken when i_valid is high
// and o_stall is low. Output channel: o_valid with i_stall.
// From the accepting edge to o_valid a beat passes two capture and square
// stages, a chain of 32 cordic cells (each also computes one digit of the
// square root), two rounding and scaling stages and the output register.
// Throughput: one beat per cycle while o_stall is low (one cell per stage).
// When the receiver stalls, the result holds in the output register and the
// next one finishes into a skid register; only once that is full does o_stall
// rise and the whole chain hold. Reset empties every stage; there is no
// state to initialize and the block takes input once reset is released.
module cartesian_polar_converter_core import cpc_pkg::*; #(
    parameter int COORD_WIDTH = 16,
    parameter int ANGLE_WIDTH = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic                   i_func,
    input  logic [COORD_WIDTH-1:0] i_x_in,
    input  logic [COORD_WIDTH-1:0] i_y_in,
    input  logic [COORD_WIDTH-1:0] i_radius_in,
    input  logic [ANGLE_WIDTH-1:0] i_angle_in,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [COORD_WIDTH-1:0] o_x_out,
    output logic [COORD_WIDTH-1:0] o_y_out,
    output logic [COORD_WIDTH-1:0] o_radius_out,
    output logic [ANGLE_WIDTH-1:0] o_angle_out
);

    localparam int CW     = COORD_WIDTH;
    localparam int AW     = ANGLE_WIDTH;
    localparam int SIDE_W = 1 + 3 * CW + AW;
    localparam int OUT_W  = 3 * CW + AW;

    logic              en;
    logic              w_valid [0:ITERS];
    t_cell_data        w_data  [0:ITERS];
    logic [SIDE_W-1:0] w_side  [0:ITERS];
    logic              post_valid;
    logic [OUT_W-1:0]  post_result;

    logic             r_out_valid;
    logic [OUT_W-1:0] r_out_result;
    logic             r_skid_valid;
    logic [OUT_W-1:0] r_skid_result;

    // the chain moves whenever the skid register is free
    assign en      = !r_skid_valid;
    assign o_stall = r_skid_valid;

    cpc_prep #(
        .COORD_WIDTH (CW),
        .ANGLE_WIDTH (AW),
        .SIDE_W      (SIDE_W)
    ) u_prep (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_valid     (i_valid),
        .i_func      (i_func),
        .i_x_in      (i_x_in),
        .i_y_in      (i_y_in),
        .i_radius_in (i_radius_in),
        .i_angle_in  (i_angle_in),
        .o_valid     (w_valid[0]),
        .o_data      (w_data[0]),
        .o_side      (w_side[0])
    );

    for (genvar g = 0; g < ITERS; g++) begin : g_cell
        cpc_cell #(
            .STAGE  (g),
            .SIDE_W (SIDE_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (w_valid[g]),
            .i_data  (w_data[g]),
            .i_side  (w_side[g]),
            .o_valid (w_valid[g+1]),
            .o_data  (w_data[g+1]),
            .o_side  (w_side[g+1])
        );
    end

    cpc_post #(
        .COORD_WIDTH (CW),
        .ANGLE_WIDTH (AW),
        .SIDE_W      (SIDE_W)
    ) u_post (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (w_valid[ITERS]),
        .i_data   (w_data[ITERS]),
        .i_side   (w_side[ITERS]),
        .o_valid  (post_valid),
        .o_result (post_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || !i_stall) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= post_valid;
            end
        end else if (post_valid && !r_skid_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || !i_stall) begin
            r_out_result <= r_skid_valid ? r_skid_result : post_result;
        end else if (!r_skid_valid) begin
            r_skid_result <= post_result;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_x_out      = r_out_result[AW+3*CW-1:AW+2*CW];
    assign o_y_out      = r_out_result[AW+2*CW-1:AW+CW];
    assign o_radius_out = r_out_result[AW+CW-1:AW];
    assign o_angle_out  = r_out_result[AW-1:0];

endmodule

[design/cpc_checker.sv]
// port-level checks of the converter and their binding to the top level
module cpc_checker #(
    parameter int COORD_WIDTH = 16,
    parameter int ANGLE_WIDTH = 16
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   o_stall,
    input logic                   o_valid,
    input logic                   i_stall,
    input logic [COORD_WIDTH-1:0] o_x_out,
    input logic [COORD_WIDTH-1:0] o_y_out,
    input logic [COORD_WIDTH-1:0] o_radius_out,
    input logic [ANGLE_WIDTH-1:0] o_angle_out
);

    // a stalled result beat stays offered
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result beat dropped while stalled");

    // back pressure only when a result is already waiting
    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with no result waiting");

    // the skid stage fills only behind a stalled output
    a_stall_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_stall) |-> $past(o_valid && i_stall))
        else $error("input stall rose without output stall");

    // zero magnitude or zero radius always gives the zero vector
    a_zero_radius: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_radius_out == '0) |-> (o_x_out == '0) && (o_y_out == '0))
        else $error("zero radius with nonzero coordinates");

endmodule

bind cartesian_polar_converter_core cpc_checker #(
    .COORD_WIDTH (COORD_WIDTH),
    .ANGLE_WIDTH (ANGLE_WIDTH)
) u_cpc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_stall      (o_stall),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_x_out      (o_x_out),
    .o_y_out      (o_y_out),
    .o_radius_out (o_radius_out),
    .o_angle_out  (o_angle_out)
);
